[rtl/crq_pkg.sv]
// Package with the shared types and constants of the connection request queue.
`default_nettype none

package crq_pkg;

    localparam int QUEUE_DEPTH = 10;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int QCNT_W      = 4;
    localparam int ID_W        = 16;
    localparam int ADDR_W      = 48;

    localparam logic [1:0] OP_CONNECT  = 2'd0;
    localparam logic [1:0] OP_ADVANCE  = 2'd1;
    localparam logic [1:0] OP_CLEANUP  = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_DUP   = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   service_id;
        logic [ADDR_W-1:0] device_addr;
        logic              stack_running;
    } crq_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              dispatch_valid;
        logic [ID_W-1:0]   dispatch_id;
        logic [ADDR_W-1:0] dispatch_addr;
        logic [QCNT_W-1:0] queue_count;
    } crq_rsp_t;

    // Contents of one queue slot, handed from a cell to its neighbor on a shift.
    typedef struct packed {
        logic              occ;
        logic              busy;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr;
    } crq_slot_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic              append;
        logic              remove_id;
        logic              remove_head;
        logic [ID_W-1:0]   key;
        logic [ADDR_W-1:0] addr;
    } crq_cmd_t;

endpackage

`default_nettype wire

[rtl/crq_cell.sv]
// One queue slot: holds a request and shifts toward the head on removal.
`default_nettype none

module crq_cell
    import crq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire crq_cmd_t  cmd,
    input  wire logic      mark_busy,
    input  wire logic      prev_occ,
    input  wire crq_slot_t nxt,
    input  wire logic      kill_in,
    output logic           kill_out,
    output logic           match,
    output crq_slot_t      cur
);

    logic              occ_reg, occ_next;
    logic              busy_reg, busy_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              load;

    assign match    = occ_reg && (id_reg == cmd.key);
    // From a removal point on, that cell and every later cell take their neighbor's slot.
    assign kill_out = kill_in || (cmd.remove_id && match);
    // The first empty cell takes an appended request.
    assign load     = cmd.append && !occ_reg && prev_occ;

    assign cur.occ  = occ_reg;
    assign cur.busy = busy_reg;
    assign cur.id   = id_reg;
    assign cur.addr = addr_reg;

    always_comb
    begin
        occ_next  = occ_reg;
        busy_next = busy_reg;
        id_next   = id_reg;
        addr_next = addr_reg;
        priority if (kill_out)
        begin
            occ_next  = nxt.occ;
            busy_next = nxt.busy;
            id_next   = nxt.id;
            addr_next = nxt.addr;
        end
        else if (load)
        begin
            occ_next  = 1'b1;
            busy_next = 1'b0;
            id_next   = cmd.key;
            addr_next = cmd.addr;
        end
        else if (mark_busy)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        addr_reg <= addr_next;
    end

endmodule

`default_nettype wire

[rtl/connection_request_queue.sv]
// Top level of the connection request queue: controller and row of slot cells.
//
// The block keeps a FIFO of up to QUEUE_DEPTH pending connection requests in a
// row of cells, head in cell zero. Each cell compares its id against the key
// in parallel; removals shift the tail of the row one cell toward the head.
// Requests arrive on the req channel (req_valid / req_stall) and each one
// produces exactly one transaction on the rsp channel (rsp_valid / rsp_stall).
// A request is accepted only while the controller is idle, then passes through
// S_MOD for the queue update (append, duplicate and full checks, removal) and
// S_DISP for the optional dispatch of the head, where the response is
// registered. A new request is not accepted until the previous one has left
// S_DISP. The response register decouples the two sides: the next request is
// taken while a finished response still waits. If the receiver stalls and the
// response register is still full, the dispatch state waits until it frees.
// Reset empties the queue and clears all busy flags and both valid signals.
`default_nettype none

module connection_request_queue
    import crq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire crq_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output crq_rsp_t      rsp
);

    typedef enum logic [1:0] {S_IDLE, S_MOD, S_DISP} state_t;

    state_t            state_reg;
    crq_req_t          req_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [1:0]        status_reg;
    logic              rsp_valid_reg;
    crq_rsp_t          rsp_reg;

    crq_cmd_t          cmd;
    crq_slot_t         slot [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]   kill;
    logic [QUEUE_DEPTH-1:0] match;
    logic              any_match;
    logic              full;
    logic              empty;
    logic              rsp_free;
    logic              do_disp;
    logic              issue;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign any_match = |match;
    assign full      = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Dispatch follows a dispatch request, and connect and advance when the stack is running.
    assign do_disp = (req_reg.op == OP_DISPATCH) ||
                     (((req_reg.op == OP_CONNECT) || (req_reg.op == OP_ADVANCE)) &&
                      req_reg.stack_running);
    assign issue   = (state_reg == S_DISP) && rsp_free && do_disp &&
                     slot[0].occ && !slot[0].busy;

    always_comb
    begin
        cmd.append      = (state_reg == S_MOD) && (req_reg.op == OP_CONNECT) &&
                          !full && !any_match;
        cmd.remove_head = (state_reg == S_MOD) && (req_reg.op == OP_ADVANCE) && !empty;
        cmd.remove_id   = (state_reg == S_MOD) && (req_reg.op == OP_CLEANUP);
        cmd.key         = req_reg.service_id;
        cmd.addr        = req_reg.device_addr;
    end

    assign kill[0] = cmd.remove_head;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic      prev_occ;
        crq_slot_t nxt;
        logic      mark;

        if (i == 0)
        begin : g_head
            assign prev_occ = 1'b1;
            assign mark     = issue;
        end
        else
        begin : g_body
            assign prev_occ = slot[i-1].occ;
            assign mark     = 1'b0;
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign nxt = '0;
        end
        else
        begin : g_link
            assign nxt = slot[i+1];
        end

        crq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .mark_busy (mark),
            .prev_occ  (prev_occ),
            .nxt       (nxt),
            .kill_in   (kill[i]),
            .kill_out  (kill[i+1]),
            .match     (match[i]),
            .cur       (slot[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= STATUS_OK;
            rsp_valid_reg <= 1'b0;
            req_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            // In the dispatch state a new response is loaded whenever the register is free,
            // otherwise the register empties once the receiver takes its transaction.
            if ((state_reg == S_DISP) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req;
                        state_reg <= S_MOD;
                    end
                end

                S_MOD:
                begin
                    unique case (req_reg.op)
                        OP_CONNECT:
                        begin
                            if (full)
                            begin
                                status_reg <= STATUS_FULL;
                            end
                            else if (any_match)
                            begin
                                status_reg <= STATUS_DUP;
                            end
                            else
                            begin
                                status_reg <= STATUS_OK;
                                count_reg  <= count_reg + 1'b1;
                            end
                        end
                        OP_ADVANCE:
                        begin
                            if (empty)
                            begin
                                status_reg <= STATUS_EMPTY;
                            end
                            else
                            begin
                                status_reg <= STATUS_OK;
                                count_reg  <= count_reg - 1'b1;
                            end
                        end
                        OP_CLEANUP:
                        begin
                            status_reg <= STATUS_OK;
                            if (any_match)
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                        OP_DISPATCH:
                        begin
                            status_reg <= STATUS_OK;
                        end
                        default:
                        begin
                            status_reg <= STATUS_OK;
                        end
                    endcase
                    state_reg <= S_DISP;
                end

                S_DISP:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg.queue_count    <= QCNT_W'(count_reg);
                        rsp_reg.dispatch_valid <= issue;
                        rsp_reg.dispatch_id    <= issue ? slot[0].id : '0;
                        rsp_reg.dispatch_addr  <= issue ? slot[0].addr : '0;
                        if ((req_reg.op == OP_DISPATCH) && !slot[0].occ)
                        begin
                            rsp_reg.status <= STATUS_EMPTY;
                        end
                        else
                        begin
                            rsp_reg.status <= status_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
